// ----- rtl/csrmv_pkg.sv -----
`default_nettype none

package csrmv_pkg;

  // Defaults for the top-level parameters
  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int ROW_BITS_DEF     = 16;

  // Result queue depth; covers the two pipeline stages plus output slack
  localparam int RESULT_DEPTH = 4;

  // Field widths
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 32;
  localparam int ROW_INDEX_W = 16;
  localparam int SUM_W       = 64;
  localparam int VLEN_W      = 11;
  localparam int RBASE_W     = 16;
  localparam int RSTOP_W     = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
  localparam logic [OP_W-1:0] OP_EMPTY   = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

  // Config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BASE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STOP      = 2'd2;

  // Config reset values
  localparam logic [VLEN_W-1:0]  VLEN_RESET  = 11'd1024;
  localparam logic [RBASE_W-1:0] RBASE_RESET = 16'd0;
  localparam logic [RSTOP_W-1:0] RSTOP_RESET = 17'd65536;

  typedef struct packed {
    logic [ROW_INDEX_W-1:0]  row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    column_error;
    logic                    last_row;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/csr_sparse_matrix_vector_multiply.sv -----
// CSR sparse matrix-vector multiply, Q16.16 operands, saturating Q32.32 row sums.
// A closing item passes the stage 1 and stage 2 registers, then the result queue.
// Throughput: one item per cycle; in_ready drops only while queued results plus
//   items in the two pipeline stages reach the four-entry result queue depth.
// Reset: config registers, accumulator, row counter and error mark take their reset
//   values; the vector store is not cleared and holds garbage until loaded.
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
  parameter int ROW_BITS     = csrmv_pkg::ROW_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input item channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [csrmv_pkg::OP_W-1:0]           op,
  input  wire logic [csrmv_pkg::INDEX_W-1:0]        index,
  input  wire logic signed [csrmv_pkg::VALUE_W-1:0] value,
  input  wire logic                                 row_end,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [csrmv_pkg::ROW_INDEX_W-1:0]         row_index,
  output logic signed [csrmv_pkg::SUM_W-1:0]        row_sum,
  output logic                                      column_error,
  output logic                                      last_row,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [csrmv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [csrmv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import csrmv_pkg::*;

  localparam int AW  = $clog2(VECTOR_DEPTH);
  // Wide enough for row_counter + 1 without wrap, and for row_stop
  localparam int LCW = (ROW_BITS + 1 > RSTOP_W) ? ROW_BITS + 1 : RSTOP_W;
  localparam int QCW = $clog2(RESULT_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Config registers. The user must write only while the block is idle; unchecked.
  // ---------------------------------------------------------------------------
  logic [VLEN_W-1:0]  vector_length;
  logic [RBASE_W-1:0] row_base;
  logic [RSTOP_W-1:0] row_stop;
  logic               cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_RESET;
      row_base      <= RBASE_RESET;
      row_stop      <= RSTOP_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_VECTOR_LENGTH: vector_length <= cfg_data[VLEN_W-1:0];
        CFG_ROW_BASE:      row_base      <= cfg_data[RBASE_W-1:0];
        CFG_ROW_STOP:      row_stop      <= cfg_data[RSTOP_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept. Loads write the vector store; every item reads it, so a
  // nonzero right after a load of the same element sees the new value.
  // ---------------------------------------------------------------------------
  logic          in_fire;
  logic          idx_in_store;
  logic          col_err;
  logic [AW-1:0] addr;

  assign in_fire      = in_valid && in_ready;
  assign idx_in_store = (32'(index) < 32'(VECTOR_DEPTH));
  assign addr         = AW'(index);
  // Column past the configured length or the physical store: no term, flag row
  assign col_err      = !idx_in_store || ({1'b0, index} >= vector_length);

  logic signed [VALUE_W-1:0] vector_store [VECTOR_DEPTH];
  logic signed [VALUE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (in_fire && (op == OP_LOAD) && idx_in_store) begin
      vector_store[addr] <= value;
    end
    if (in_fire) begin
      mem_rdata <= vector_store[addr];
    end
  end

  // Stage 1 registers
  logic                      s1_v;
  logic [OP_W-1:0]           s1_op;
  logic signed [VALUE_W-1:0] s1_val;
  logic                      s1_end;
  logic                      s1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op  <= op;
      s1_val <= value;
      s1_end <= row_end;
      s1_err <= col_err;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: Q16.16 x Q16.16 -> exact Q32.32 product, registered.
  // ---------------------------------------------------------------------------
  logic                    s2_v;
  logic [OP_W-1:0]         s2_op;
  logic                    s2_end;
  logic                    s2_err;
  logic signed [SUM_W-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_op   <= s1_op;
    s2_end  <= s1_end;
    s2_err  <= s1_err;
    s2_prod <= s1_val * mem_rdata;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: saturating accumulate, row close, restart.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] acc;
  logic                    err_mark;
  logic [ROW_BITS-1:0]     row_cnt;

  logic signed [SUM_W-1:0] sum_raw;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [SUM_W-1:0] acc_new;
  logic                    err_new;
  logic                    is_nz;
  logic                    emit;
  logic                    restart;
  logic [LCW-1:0]          row_next_wide;
  result_t                 res_data;

  always_comb begin
    sum_raw = acc + s2_prod;
    // Overflow only when both addends share a sign and the sum does not
    if ((acc[SUM_W-1] == s2_prod[SUM_W-1]) && (sum_raw[SUM_W-1] != acc[SUM_W-1])) begin
      sum_sat = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_raw;
    end
  end

  assign is_nz   = s2_v && (s2_op == OP_NONZERO);
  assign acc_new = (is_nz && !s2_err) ? sum_sat : acc;
  assign err_new = err_mark || (is_nz && s2_err);
  assign emit    = (s2_v && (s2_op == OP_EMPTY)) || (is_nz && s2_end);
  assign restart = s2_v && (s2_op == OP_RESTART);

  // last_row compares without wrap, so a zero row_stop never matches
  assign row_next_wide = LCW'(row_cnt) + 1'b1;

  always_comb begin
    res_data.row_index    = ROW_INDEX_W'(row_cnt);
    res_data.row_sum      = acc_new;
    res_data.column_error = err_new;
    res_data.last_row     = (row_next_wide == LCW'(row_stop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      err_mark <= 1'b0;
      row_cnt  <= ROW_BITS'(32'(RBASE_RESET));
    end else if (restart) begin
      acc      <= '0;
      err_mark <= 1'b0;
      row_cnt  <= ROW_BITS'(32'(row_base));
    end else if (emit) begin
      acc      <= '0;
      err_mark <= 1'b0;
      row_cnt  <= row_cnt + 1'b1;
    end else if (is_nz) begin
      acc      <= acc_new;
      err_mark <= err_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. Credit counts every item in flight as a possible result, so
  // the pipeline never stalls and a push always finds room.
  // ---------------------------------------------------------------------------
  result_t        head;
  logic [QCW-1:0] q_count;
  logic [QCW:0]   credit_used;

  csrmv_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (emit),
    .push_data  (res_data),
    .pop        (out_valid && out_ready),
    .head_data  (head),
    .head_valid (out_valid),
    .count      (q_count)
  );

  assign credit_used = (QCW+1)'(q_count) + (QCW+1)'(s1_v) + (QCW+1)'(s2_v);
  assign in_ready    = (credit_used < (QCW+1)'(RESULT_DEPTH));

  assign row_index    = head.row_index;
  assign row_sum      = head.row_sum;
  assign column_error = head.column_error;
  assign last_row     = head.last_row;

`ifndef SYNTH
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    emit |-> (q_count < QCW'(RESULT_DEPTH)))
    else $error("result pushed into full queue");

  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    (emit || restart) |=> ((acc == '0) && !err_mark))
    else $error("row state not cleared after close or restart");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    (emit && !restart) |=> (row_cnt == $past(row_cnt) + 1'b1))
    else $error("row counter did not advance after a result");

  a_bad_col_no_term: assert property (@(posedge clk) disable iff (rst)
    (is_nz && s2_err && !emit) |=> ($stable(acc) && err_mark))
    else $error("out-of-range column changed the sum or lost its flag");
`endif

endmodule

`default_nettype wire

// ----- rtl/csrmv_result_fifo.sv -----
`default_nettype none

module csrmv_result_fifo #(
  parameter int DEPTH = csrmv_pkg::RESULT_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire csrmv_pkg::result_t         push_data,
  input  wire logic                       pop,
  output csrmv_pkg::result_t              head_data,
  output logic                            head_valid,
  output logic [$clog2(DEPTH+1)-1:0]      count
);
  import csrmv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  result_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_data  = slots[rd_ptr];
  assign head_valid = (count != CW'(0));

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
  import csrmv_pkg::*;

  // Watchdog in clock cycles: well above the slowest legal run with every
  // item waiting out the longest sender gap and receiver stall
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Random items per handshake phase; four phases give about 1100 items
  localparam int unsigned PHASE_ITEMS = 275;
  // Cycles to let the pipeline settle once no row sum is outstanding
  localparam int unsigned SETTLE_CYCLES = 4;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           op = OP_LOAD;
  logic [INDEX_W-1:0]        index = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      row_end = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ROW_INDEX_W-1:0]    row_index;
  logic signed [SUM_W-1:0]   row_sum;
  logic                      column_error;
  logic                      last_row;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = CFG_VECTOR_LENGTH;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  csr_sparse_matrix_vector_multiply u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .index        (index),
    .value        (value),
    .row_end      (row_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_index    (row_index),
    .row_sum      (row_sum),
    .column_error (column_error),
    .last_row     (last_row),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Row-sum predictor plus the queue of row sums still owed by the block.
  // It keeps its own copy of the dense vector, the running row state and
  // the three config registers.
  class row_sum_scoreboard;
    logic signed [VALUE_W-1:0] vector_copy [VECTOR_DEPTH_DEF];
    logic signed [SUM_W-1:0]   acc;
    logic [ROW_INDEX_W-1:0]    row_num;
    logic                      err_mark;
    logic [VLEN_W-1:0]         vector_len;
    logic [RBASE_W-1:0]        first_row;
    logic [RSTOP_W-1:0]        end_row;
    result_t                   pending_rows [$];
    int unsigned               errors;
    int unsigned               rows_checked;
    int unsigned               flagged_rows;
    int unsigned               saturated_rows;
    int unsigned               last_rows;

    function new();
      vector_len     = VLEN_RESET;
      first_row      = RBASE_RESET;
      end_row        = RSTOP_RESET;
      acc            = '0;
      row_num        = RBASE_RESET;
      err_mark       = 1'b0;
      errors         = 0;
      rows_checked   = 0;
      flagged_rows   = 0;
      saturated_rows = 0;
      last_rows      = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void take_config(logic [CFG_INDEX_W-1:0] reg_idx, logic [CFG_DATA_W-1:0] data);
      case (reg_idx)
        CFG_VECTOR_LENGTH: vector_len = data[VLEN_W-1:0];
        CFG_ROW_BASE:      first_row  = data[RBASE_W-1:0];
        CFG_ROW_STOP:      end_row    = data[RSTOP_W-1:0];
        default: ;
      endcase
    endfunction

    // Emit the current row, then clear and step the row counter (wraps)
    function void close_row();
      result_t r;
      r.row_index    = row_num;
      r.row_sum      = acc;
      r.column_error = err_mark;
      r.last_row     = ({1'b0, row_num} + 17'd1) == end_row;
      pending_rows.push_back(r);
      acc      = '0;
      err_mark = 1'b0;
      row_num  = row_num + 1'b1;
    endfunction

    // Called for every accepted input item, in acceptance order
    function void take_item(logic [OP_W-1:0] kind, logic [INDEX_W-1:0] col,
                            logic signed [VALUE_W-1:0] val, logic closes);
      logic signed [SUM_W-1:0] term;
      logic signed [SUM_W-1:0] total;
      case (kind)
        OP_LOAD:    vector_copy[col] = val;
        OP_RESTART: begin
          row_num  = first_row;
          acc      = '0;
          err_mark = 1'b0;
        end
        OP_EMPTY:   close_row();
        default: begin
          if (col >= vector_len) begin
            err_mark = 1'b1;
          end else begin
            // Q16.16 x Q16.16 is exact in Q32.32; only the add can overflow
            term  = longint'(val) * longint'(vector_copy[col]);
            total = acc + term;
            if (acc[SUM_W-1] == term[SUM_W-1] && total[SUM_W-1] != acc[SUM_W-1])
              total = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
            acc = total;
          end
          if (closes)
            close_row();
        end
      endcase
    endfunction

    task check_row(logic [ROW_INDEX_W-1:0] got_index, logic signed [SUM_W-1:0] got_sum,
                   logic got_err, logic got_last);
      result_t want;
      if (pending_rows.size() == 0) begin
        report($sformatf("row %0d sum %0h arrived with nothing outstanding",
                         got_index, got_sum));
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (want.column_error) flagged_rows++;
        if (want.last_row) last_rows++;
        if (want.row_sum == SUM_MAX || want.row_sum == SUM_MIN) saturated_rows++;
        if (got_index !== want.row_index)
          report($sformatf("row_index got %0d expected %0d", got_index, want.row_index));
        if (got_sum !== want.row_sum)
          report($sformatf("row %0d: row_sum got %0h expected %0h",
                           want.row_index, got_sum, want.row_sum));
        if (got_err !== want.column_error)
          report($sformatf("row %0d: column_error got %b expected %b",
                           want.row_index, got_err, want.column_error));
        if (got_last !== want.last_row)
          report($sformatf("row %0d: last_row got %b expected %b",
                           want.row_index, got_last, want.last_row));
      end
    endtask
  endclass

  row_sum_scoreboard sb;

  // Per-phase idling, in percent of cycles
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  // Vector length as last written; steers column choice in or out of range
  int unsigned cur_vlen = 32'(VLEN_RESET);

  // Vector entries loaded so far. Nonzero columns are drawn only from this
  // list, so no nonzero takes its term from an entry that was never written.
  bit          is_loaded [VECTOR_DEPTH_DEF];
  int unsigned loaded_list [$];

  initial forever #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check on handshake, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_row(row_index, row_sum, column_error, last_row);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Mix of extremes, small Q16.16 magnitudes and raw random words
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return $urandom_range(32'h0004_0000);
      5:       return -$urandom_range(32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  // Loaded column, preferably inside (or outside) the current vector length
  function automatic logic [INDEX_W-1:0] pick_column(bit in_range);
    int unsigned col;
    col = loaded_list[$urandom_range(loaded_list.size() - 1)];
    for (int k = 0; k < 8 && ((col < cur_vlen) != in_range); k++)
      col = loaded_list[$urandom_range(loaded_list.size() - 1)];
    return col[INDEX_W-1:0];
  endfunction

  // Called just after the clock rises. Valid only drops for a gap, so
  // back-to-back items keep it high without a second update in one step.
  task automatic send_item(logic [OP_W-1:0] kind, logic [INDEX_W-1:0] col,
                           logic [VALUE_W-1:0] val, logic closes);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    op       <= kind;
    index    <= col;
    value    <= val;
    row_end  <= closes;
    do @(posedge clk); while (!in_ready);
    sb.take_item(kind, col, val, closes);
    items_sent++;
  endtask

  task automatic send_load(logic [INDEX_W-1:0] col, logic [VALUE_W-1:0] val);
    send_item(OP_LOAD, col, val, 1'b0);
    if (!is_loaded[col]) begin
      is_loaded[col] = 1'b1;
      loaded_list.push_back(col);
    end
  endtask

  // A run of nonzeros; with closed set the last carries the end mark
  task automatic send_row(int unsigned terms, bit closed);
    for (int k = 0; k < terms; k++)
      send_item(OP_NONZERO, pick_column($urandom_range(99) < 85), rand_value(),
                closed && (k == terms - 1));
  endtask

  // Stop sending and wait until every row sum owed has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers; only called with the block idle
  task automatic configure(int unsigned vlen, int unsigned base, int unsigned stop);
    logic [CFG_INDEX_W-1:0] reg_idx [3];
    logic [CFG_DATA_W-1:0]  reg_val [3];
    reg_idx[0] = CFG_VECTOR_LENGTH;
    reg_idx[1] = CFG_ROW_BASE;
    reg_idx[2] = CFG_ROW_STOP;
    reg_val[0] = vlen[CFG_DATA_W-1:0];
    reg_val[1] = base[CFG_DATA_W-1:0];
    reg_val[2] = stop[CFG_DATA_W-1:0];
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[r];
      cfg_data  <= reg_val[r];
      do @(posedge clk); while (!cfg_ready);
      sb.take_config(reg_idx[r], reg_val[r]);
    end
    cfg_valid <= 1'b0;
    cur_vlen = vlen;
  endtask

  // One random phase: mostly well-formed rows with random content, plus
  // loads, restarts, empty rows, rows cut short by an empty row or a
  // restart, and rows with a load landing mid-row.
  task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned vlen,
                           int unsigned base, int unsigned stop, bit pause_midway);
    int unsigned goal;
    int unsigned half;
    int unsigned pick;
    wait_idle();
    gap_pct   = gap;
    stall_pct = stall;
    configure(vlen, base, stop);
    goal = items_sent + PHASE_ITEMS;
    half = items_sent + PHASE_ITEMS / 2;
    send_item(OP_RESTART, pick_column(1'b1), rand_value(), 1'b0);
    while (items_sent < goal) begin
      if (pause_midway && items_sent >= half) begin
        // sender holds off until the block has drained
        wait_idle();
        pause_midway = 1'b0;
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(OP_RESTART, pick_column(1'($urandom_range(1))), rand_value(),
                  1'($urandom_range(1)));
      end else if (pick < 18) begin
        send_load(INDEX_W'($urandom_range(VECTOR_DEPTH_DEF - 1)), rand_value());
      end else if (pick < 26) begin
        send_item(OP_EMPTY, pick_column(1'($urandom_range(1))), rand_value(),
                  1'($urandom_range(1)));
      end else if (pick < 34) begin
        send_row($urandom_range(1, 4), 1'b0);
        case ($urandom_range(2))
          0: send_item(OP_EMPTY, pick_column(1'b1), rand_value(), 1'b0);
          1: send_item(OP_RESTART, pick_column(1'b1), rand_value(), 1'b1);
          default: begin
            send_load(INDEX_W'($urandom_range(VECTOR_DEPTH_DEF - 1)), rand_value());
            send_row($urandom_range(1, 3), 1'b1);
          end
        endcase
      end else begin
        send_row($urandom_range(1, 6), 1'b1);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset config: index extremes and alternating bit patterns
    send_load(10'd0,    32'h7FFF_FFFF);
    send_load(10'd1023, 32'h8000_0000);
    send_load(10'd512,  32'h0001_0000);
    send_load(10'd341,  32'hFFFF_FFFF);
    send_load(10'd682,  32'h1234_5678);
    // positive overflow: two (-1<<31)^2 terms pass the top, stays pinned
    send_item(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd512,  32'h7FFF_FFFF, 1'b1);
    // negative overflow
    send_item(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b1);
    // empty row gives zero
    send_item(OP_EMPTY, 10'd0, 32'h0, 1'b0);
    // empty row closes a row left open
    send_item(OP_NONZERO, 10'd682, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_EMPTY, 10'd0, 32'h0, 1'b0);
    send_item(OP_NONZERO, 10'd341, 32'h0001_0000, 1'b1);
    // restart puts the row count back to the base
    send_item(OP_RESTART, 10'd0, 32'h0, 1'b0);
    send_item(OP_NONZERO, 10'd512, 32'h0000_0001, 1'b1);

    // Directed, short vector and rows at the top of the range
    wait_idle();
    configure(1, 32'hFFFE, 32'hFFFF);
    // new base not applied until the next restart
    send_item(OP_EMPTY, 10'd0, 32'h0, 1'b0);
    send_item(OP_RESTART, 10'd0, 32'h0, 1'b0);
    // column past the vector length: flagged, adds nothing, last row
    send_item(OP_NONZERO, 10'd512, 32'h0000_0005, 1'b1);
    send_item(OP_NONZERO, 10'd0, 32'h0001_0000, 1'b0);
    send_item(OP_NONZERO, 10'd1023, 32'h0000_0007, 1'b1);
    // row counter wraps past the top
    send_item(OP_EMPTY, 10'd0, 32'h0, 1'b0);
    // load landing between two terms of one row
    send_item(OP_NONZERO, 10'd0, 32'h0001_0000, 1'b0);
    send_load(10'd0, 32'h0002_0000);
    send_item(OP_NONZERO, 10'd0, 32'h0001_0000, 1'b1);

    // Random phases
    run_phase(0,  0,  32'(VLEN_RESET), 0, 32'(RSTOP_RESET), 1'b0);
    run_phase(66, 0,  1,          65535, 0,           1'b0);
    run_phase(0,  66, $urandom_range(2, 1023), $urandom_range(65535),
              0, 1'b1);
    run_phase(28, 28, 600,        0,     1,           1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.pending_rows.size() != 0)
      sb.report($sformatf("%0d row sums never arrived", sb.pending_rows.size()));

    $display("Run covered %0d items over four idling phases and %0d config settings",
             items_sent, 6);
    $display("Row sums checked: %0d (%0d flagged, %0d saturated, %0d last-row)",
             sb.rows_checked, sb.flagged_rows, sb.saturated_rows, sb.last_rows);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
